// ----- hw/rtl/crcf_pkg.sv -----
// Shared types, constants and the CRC byte update for the CRC-16 frame block.
// No dependencies; every other RTL file uses this package by scoped names.
`default_nettype none
package crcf_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    // job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one accepted input byte turns into at most three output words
    localparam int JOB_MAX = 3;
    localparam int JOB_IDX_W = $clog2(JOB_MAX + 1);

    typedef struct packed {
        logic [JOB_IDX_W-1:0]         cnt;    // words in this job, 1..3
        logic [JOB_MAX-1:0][7:0]      bytes;  // word payloads, [0] goes first
        logic                         eof;    // end_of_frame on the final word
        logic                         ok;     // frame_ok on the final word
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // reflected CRC-16, one byte, bit-serial form unrolled
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/crcf_front.sv -----
// Front end: accepts frame bytes, keeps the two-byte hold window and the running
// CRC, and turns accepted bytes into jobs for the back end (a byte that releases no word gives none). Uses crcf_pkg.
`default_nettype none
module crcf_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           check_mode,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     data_byte,
    input  wire logic           frame_last,
    input  wire crcf_pkg::q_stat_t q_stat,
    output logic                push,
    output crcf_pkg::job_t      job
);

    logic [15:0] crc_reg, crc_next;
    logic [1:0]  held_cnt_reg, held_cnt_next;
    logic [7:0]  held_reg [2];
    logic [7:0]  held_next [2];

    logic        in_fire;
    logic        gen;
    logic [15:0] fold_crc;
    logic [15:0] frame_crc;
    logic [7:0]  lo_slot;

    assign in_ready = !q_stat.full;
    assign in_fire  = in_valid && in_ready;
    assign gen      = !check_mode;
    assign fold_crc = crcf_pkg::crc_fold(crc_reg, held_reg[0]);
    assign frame_crc = (held_cnt_reg == 2'd2) ? fold_crc : crc_reg;
    assign lo_slot   = (held_cnt_reg == 2'd2) ? held_reg[1] : held_reg[0];

    always_comb
    begin
        crc_next      = crc_reg;
        held_cnt_next = held_cnt_reg;
        held_next[0]  = held_reg[0];
        held_next[1]  = held_reg[1];
        push          = 1'b0;
        job           = '0;
        if (in_fire)
        begin
            if (!frame_last)
            begin
                if (held_cnt_reg == 2'd2)
                begin
                    // window full: oldest byte leaves through the CRC
                    crc_next     = fold_crc;
                    held_next[0] = held_reg[1];
                    held_next[1] = data_byte;
                    if (gen)
                    begin
                        push         = 1'b1;
                        job.cnt      = crcf_pkg::JOB_IDX_W'(1);
                        job.bytes[0] = held_reg[0];
                    end
                end
                else
                begin
                    held_next[held_cnt_reg[0]] = data_byte;
                    held_cnt_next = held_cnt_reg + 2'd1;
                end
            end
            else
            begin
                crc_next      = crcf_pkg::CRC_INIT;
                held_cnt_next = 2'd0;
                push          = 1'b1;
                job.eof       = 1'b1;
                if (held_cnt_reg == 2'd0)
                begin
                    // one-byte frame
                    job.cnt      = crcf_pkg::JOB_IDX_W'(1);
                    job.bytes[0] = gen ? data_byte : 8'h00;
                end
                else if (gen)
                begin
                    if (held_cnt_reg == 2'd2)
                    begin
                        job.cnt      = crcf_pkg::JOB_IDX_W'(3);
                        job.bytes[0] = held_reg[0];
                        job.bytes[1] = frame_crc[7:0];
                        job.bytes[2] = frame_crc[15:8];
                    end
                    else
                    begin
                        job.cnt      = crcf_pkg::JOB_IDX_W'(2);
                        job.bytes[0] = frame_crc[7:0];
                        job.bytes[1] = frame_crc[15:8];
                    end
                end
                else
                begin
                    job.cnt = crcf_pkg::JOB_IDX_W'(1);
                    job.ok  = ({data_byte, lo_slot} == frame_crc);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= crcf_pkg::CRC_INIT;
            held_cnt_reg <= 2'd0;
        end
        else
        begin
            crc_reg      <= crc_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    // window bytes are only read below the fill count
    always_ff @(posedge clk)
    begin
        held_reg[0] <= held_next[0];
        held_reg[1] <= held_next[1];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/crcf_queue.sv -----
// Small job FIFO that decouples the front end from the output side.
// Depth from crcf_pkg::QDEPTH; uses crcf_pkg types.
`default_nettype none
module crcf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire crcf_pkg::job_t push_job,
    input  wire logic           pop,
    output crcf_pkg::job_t      head,
    output crcf_pkg::q_stat_t   stat
);

    localparam logic [crcf_pkg::QPTR_W-1:0] PTR_LAST = crcf_pkg::QPTR_W'(crcf_pkg::QDEPTH - 1);
    localparam logic [crcf_pkg::QCNT_W-1:0] CNT_FULL = crcf_pkg::QCNT_W'(crcf_pkg::QDEPTH);

    crcf_pkg::job_t                 entry_reg [crcf_pkg::QDEPTH];
    logic [crcf_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [crcf_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [crcf_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/crcf_back.sv -----
// Back end: takes jobs from the queue and plays out their words, one per cycle while
// out_ready does not stall, into the output register. Uses crcf_pkg types.
`default_nettype none
module crcf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire crcf_pkg::job_t head,
    input  wire crcf_pkg::q_stat_t q_stat,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                end_of_frame,
    output logic                frame_ok
);

    crcf_pkg::job_t                 job_reg, job_next;
    logic                           job_valid_reg, job_valid_next;
    logic [crcf_pkg::JOB_IDX_W-1:0] idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     out_byte_reg, out_byte_next;
    logic                           eof_reg, eof_next;
    logic                           ok_reg, ok_next;

    crcf_pkg::job_t                 cur;
    logic [crcf_pkg::JOB_IDX_W-1:0] cur_idx;
    logic                           cur_valid;
    logic                           load;
    logic                           last_word;

    // a parked multi-word job goes ahead of the queue head
    assign cur       = job_valid_reg ? job_reg : head;
    assign cur_idx   = job_valid_reg ? idx_reg : '0;
    assign cur_valid = job_valid_reg || !q_stat.empty;
    assign load      = cur_valid && (!out_valid_reg || out_ready);
    assign last_word = (cur_idx == cur.cnt - 1'b1);
    assign pop       = load && !job_valid_reg;

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        out_byte_next  = out_byte_reg;
        eof_next       = eof_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur.bytes[cur_idx];
            eof_next       = cur.eof && last_word;
            ok_next        = cur.ok && last_word;
            if (last_word)
            begin
                job_valid_next = 1'b0;
            end
            else
            begin
                job_next       = cur;
                job_valid_next = 1'b1;
                idx_next       = cur_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_byte_reg <= out_byte_next;
        eof_reg      <= eof_next;
        ok_reg       <= ok_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign end_of_frame = eof_reg;
    assign frame_ok     = ok_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/crc16_frame_append_check_top.sv -----
// CRC-16 (reflected 0x8408, init 0xFFFF) trailer generator / checker, top level.
// Instantiates crcf_front, crcf_queue and crcf_back; uses crcf_pkg.
`default_nettype none
// Frames arrive one byte per word with two trailing CRC slots; frame_last marks
// the final slot. With cfg_data = 0 (generate) body bytes come out delayed by two
// words and the slots are replaced by the CRC, low byte first; with cfg_data = 1
// (check) each frame gives one word with out_byte = 0, end_of_frame = 1 and the
// verdict on frame_ok. One input byte is accepted per cycle. Each byte becomes a
// job of zero to three output words, and the output side plays out one word per
// cycle while out_ready does not stall it, so a frame end in generate mode (up to
// three words) takes longer to play out than to accept; a two-entry job queue
// absorbs this, and input stalls only when it is full. Write the mode only while
// no frame words are outstanding.
module crc16_frame_append_check_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            end_of_frame,
    output logic            frame_ok
);

    logic              check_mode_reg;
    logic              q_push;
    logic              q_pop;
    crcf_pkg::job_t    q_in_job;
    crcf_pkg::job_t    q_head;
    crcf_pkg::q_stat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            check_mode_reg <= cfg_data;
        end
    end

    crcf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .check_mode (check_mode_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .q_stat     (q_stat),
        .push       (q_push),
        .job        (q_in_job)
    );

    crcf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    crcf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_stat       (q_stat),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .frame_ok     (frame_ok)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

    a_verdict_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_ok) |-> (end_of_frame && out_byte == 8'h00))
        else $error("pass verdict on a non-verdict word");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_crc16_frame_append_check_top.sv -----
// Testbench for crc16_frame_append_check_top: random and directed frames in both modes,
// with a built-in CRC-16 frame predictor checked word by word. Needs only the RTL.
`default_nettype none
module tb_crc16_frame_append_check_top;

    localparam logic        MODE_GEN     = 1'b0;
    localparam logic        MODE_CHECK   = 1'b1;
    localparam logic [15:0] CRC_SEED     = 16'hFFFF;
    localparam logic [15:0] POLY_REFL    = 16'h8408;
    localparam int          RANDOM_ITEMS = 250;
    localparam int          SETTLE       = 4;
    localparam int          IDLE_LIMIT   = 3000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       ok;
    } out_word_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic       cfg_data   = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte  = 8'h00;
    logic       frame_last = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_byte;
    logic       end_of_frame;
    logic       frame_ok;

    crc16_frame_append_check_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .frame_ok     (frame_ok)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    frame_byte_t pending[$];
    out_word_t   word_q[$];
    logic [7:0]  frame_body[$];
    int          n_queued   = 0;
    int          n_taken    = 0;
    int          n_words    = 0;
    int          mismatches = 0;
    bit          quiet      = 1'b0;

    // predictor state
    logic        chk_mode = MODE_GEN;
    logic [15:0] run_crc  = CRC_SEED;
    logic [7:0]  win[2];
    logic [1:0]  win_cnt  = 2'd0;

    // bit-at-a-time reflected update
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ b[i])
                r = (r >> 1) ^ POLY_REFL;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_word(input logic [7:0] d, input logic eof, input logic ok);
        out_word_t w;
        w.data = d;
        w.eof  = eof;
        w.ok   = ok;
        word_q.push_back(w);
    endtask

    // expected words caused by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [15:0] crc;
        logic [7:0]  lo_slot;
        logic        gen;
        gen = (chk_mode == MODE_GEN);
        if (!last)
        begin
            if (win_cnt == 2'd2)
            begin
                run_crc = crc_step(run_crc, win[0]);
                if (gen)
                    push_word(win[0], 1'b0, 1'b0);
                win[0] = win[1];
                win[1] = b;
            end
            else
            begin
                win[win_cnt[0]] = b;
                win_cnt = win_cnt + 2'd1;
            end
        end
        else
        begin
            if (win_cnt == 2'd0)
                push_word(gen ? b : 8'h00, 1'b1, 1'b0);
            else
            begin
                crc     = run_crc;
                lo_slot = win[0];
                if (win_cnt == 2'd2)
                begin
                    crc = crc_step(crc, win[0]);
                    if (gen)
                        push_word(win[0], 1'b0, 1'b0);
                    lo_slot = win[1];
                end
                if (gen)
                begin
                    push_word(crc[7:0], 1'b0, 1'b0);
                    push_word(crc[15:8], 1'b1, 1'b0);
                end
                else
                    push_word(8'h00, 1'b1, ({b, lo_slot} == crc));
            end
            run_crc = CRC_SEED;
            win_cnt = 2'd0;
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("ERROR word %0d: %s", n_words, msg);
    endtask

    // input driver
    int          gap_left = 0;
    frame_byte_t drv_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= 8'h00;
            frame_last <= 1'b0;
            gap_left   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending.size() > 0)
            begin
                drv_item   = pending.pop_front();
                in_valid   <= 1'b1;
                data_byte  <= drv_item.data;
                frame_last <= drv_item.last;
                gap_left   <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output back-pressure
    int stall_left = 0;
    int stall_pick;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_pick = pick_gap();
            if (stall_pick > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_pick - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: track mode, predict on input, check on output
    out_word_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                chk_mode = cfg_data;
            if (in_valid && in_ready)
            begin
                predict_byte(data_byte, frame_last);
                n_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (word_q.size() == 0)
                    note_mismatch($sformatf("unexpected word, out_byte %02h eof %0b ok %0b",
                                            out_byte, end_of_frame, frame_ok));
                else
                begin
                    want = word_q.pop_front();
                    if (out_byte !== want.data)
                        note_mismatch($sformatf("out_byte %02h, expected %02h",
                                                out_byte, want.data));
                    if (end_of_frame !== want.eof)
                        note_mismatch($sformatf("end_of_frame %0b, expected %0b",
                                                end_of_frame, want.eof));
                    if (frame_ok !== want.ok)
                        note_mismatch($sformatf("frame_ok %0b, expected %0b",
                                                frame_ok, want.ok));
                end
                n_words++;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TIMEOUT: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic last);
        frame_byte_t it;
        it.data = b;
        it.last = last;
        pending.push_back(it);
        n_queued++;
    endtask

    // frame_body plus a two-byte trailer, corrupted in one bit if not good
    task automatic add_frame(input logic good);
        logic [15:0] crc;
        crc = CRC_SEED;
        for (int i = 0; i < frame_body.size(); i++)
        begin
            crc = crc_step(crc, frame_body[i]);
            add_byte(frame_body[i], 1'b0);
        end
        if (!good)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        add_byte(crc[7:0], 1'b0);
        add_byte(crc[15:8], 1'b1);
    endtask

    task automatic add_random_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 8)
            add_byte(rand_byte(), 1'b1);
        else
        begin
            len = (kind < 85) ? $urandom_range(0, 6) : $urandom_range(7, 18);
            frame_body.delete();
            repeat (len) frame_body.push_back(rand_byte());
            add_frame($urandom_range(0, 3) != 0);
        end
    endtask

    task automatic write_mode(input logic m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (n_taken < n_queued || word_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    int n_directed;
    int r;

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // generate mode: short frames, then a frame left open
        write_mode(MODE_GEN);
        add_byte(8'hA5, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        frame_body = '{8'hFF, 8'h00};
        add_frame(1'b1);
        add_byte(8'h80, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h7F, 1'b0);
        wait_idle();

        // check mode: finish the open frame, then good and bad trailers
        write_mode(MODE_CHECK);
        add_byte(8'hFE, 1'b1);
        add_byte(8'h00, 1'b1);
        frame_body.delete();
        add_frame(1'b1);
        frame_body = '{8'h55, 8'hAA, 8'hFF};
        add_frame(1'b1);
        frame_body = '{8'h00};
        add_frame(1'b0);
        wait_idle();
        n_directed = n_queued;

        while (n_queued < n_directed + RANDOM_ITEMS)
        begin
            write_mode(1'($urandom_range(0, 1)));
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 5)) add_random_frame();
            r = $urandom_range(0, 99);
            if (r < 12)
                repeat ($urandom_range(1, 4)) add_byte(rand_byte(), 1'b0);
            else if (r < 20)
                repeat ($urandom_range(2, 6)) add_byte(rand_byte(), $urandom_range(0, 2) == 0);
            wait_idle();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
